FILE: rtl/mlwb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merging line write buffer package
// Shared command and status codes, controller state and control structs.
// ----------------------------------------------------------------------------
package mlwb_pkg;

  localparam int DefBufferDepth = 8;
  localparam int DefLineWords   = 16;

  typedef enum logic [2:0] {
    CMD_ENQ   = 3'd0,
    CMD_MERGE = 3'd1,
    CMD_LOAD  = 3'd2,
    CMD_ISSUE = 3'd3,
    CMD_RESP  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_HIT  = 3'd1,
    ST_BUSY = 3'd2,
    ST_MISS = 3'd3,
    ST_FULL = 3'd4,
    ST_IDLE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MERGE,
    S_ISSUE,
    S_OUT
  } state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    load_in;     // capture the input word
    logic    look;        // register match result and read line store
    logic    enq;         // perform enqueue
    logic    merge_wr;    // write merged word
    logic    mark_sent;   // mark head sent
    logic    retire;      // retire head
    logic    issue_rd;    // read next issue word
    logic    out_load;    // load output register
    status_t out_status;
    logic    out_issue;   // output carries issue fields
    logic    out_last;
  } ctl_t;

  // Datapath -> controller status.
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic hit;
    logic hit_sent;
    logic head_ok;     // head valid and not sent, count nonzero
    logic head_sent;   // head valid and sent
    logic issue_end;   // last issue word read
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/merging_line_write_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merging line write buffer
// FIFO of dirty lines with store merge, load bypass, issue and retire.
// ----------------------------------------------------------------------------
// Enqueue, merge, bypass and response capture the command word, register the
// match result and the line store read, then load their word into the output
// register once it is free; the next command word is accepted only after that.
// Issue alternates between reading the next word of the head line through the
// registered read port and loading it into the output register once it is free.
// Reset (rst, synchronous) empties the buffer; line data is not cleared.
module merging_line_write_buffer #(
  parameter int BUFFER_DEPTH = mlwb_pkg::DefBufferDepth,
  parameter int LINE_WORDS   = mlwb_pkg::DefLineWords
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[2:0], address[34:3], word_index[38:35], data_word[70:39],
  // byte_strobe[74:71], zero fill to 80
  input  wire logic [79:0] s_tdata,
  input  wire logic        s_tlast,  // last_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], read_data[34:3], issue_address[66:35], issue_word_index[70:67],
  // accept_ready[71], occupancy[75:72], zero fill to 80
  output logic [79:0]      m_tdata,
  output logic             m_tlast
);
  import mlwb_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic out_valid, o_last, o_ready;
  logic [2:0] o_status;
  logic [31:0] o_data, o_iaddr;
  logic [3:0] o_iidx, o_occ;
  logic out_free;

  // The output register may be refilled when empty or being drained.
  assign out_free = !out_valid || m_tready;

  mlwb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_free(out_free), .ctl(ctl), .sts(sts)
  );

  mlwb_dpath #(.BUFFER_DEPTH(BUFFER_DEPTH), .LINE_WORDS(LINE_WORDS)) u_dpath (
    .clk(clk), .rst(rst),
    .in_cmd(s_tdata[2:0]), .in_addr(s_tdata[34:3]),
    .in_widx(s_tdata[38:35]), .in_data(s_tdata[70:39]),
    .in_strb(s_tdata[74:71]), .in_lastw(s_tlast),
    .ctl(ctl), .sts(sts), .out_take(m_tready), .out_valid(out_valid),
    .o_status(o_status), .o_data(o_data), .o_iaddr(o_iaddr), .o_iidx(o_iidx),
    .o_last(o_last), .o_ready(o_ready), .o_occ(o_occ)
  );

  assign m_tvalid = out_valid;
  assign m_tlast = o_last;
  assign m_tdata = {4'd0, o_occ, o_ready, o_iidx, o_iaddr, o_data, o_status};

`ifndef NO_ASSERTIONS
  // Nothing is accepted while a command is still being worked on.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted during command");
  // A result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || m_tready))
    else $error("result overwritten");
  // Merge write and enqueue never collide.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(ctl.enq && ctl.merge_wr))
    else $error("two line store writes");
`endif

endmodule
`default_nettype wire

FILE: rtl/mlwb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merging line write buffer controller
// Sequences one command at a time and drives the datapath.
// ----------------------------------------------------------------------------
module mlwb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_free,
  output mlwb_pkg::ctl_t     ctl,
  input  wire mlwb_pkg::sts_t sts
);
  import mlwb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.out_status = ST_IDLE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.look = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        // Decide and answer; issue streams.
        if (out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = 1'b1;
          state_next = S_IDLE;
          unique case (sts.cmd)
            CMD_ENQ: begin
              ctl.out_status = sts.full ? ST_FULL : ST_DONE;
              ctl.enq = !sts.full;
            end
            CMD_MERGE: begin
              if (!sts.hit) ctl.out_status = ST_MISS;
              else if (sts.hit_sent) ctl.out_status = ST_BUSY;
              else begin
                ctl.out_status = ST_HIT;
                ctl.merge_wr = 1'b1;
              end
            end
            CMD_LOAD: ctl.out_status = sts.hit ? ST_HIT : ST_MISS;
            CMD_ISSUE: begin
              if (sts.head_ok) begin
                ctl.out_load = 1'b0;
                ctl.out_last = 1'b0;
                ctl.mark_sent = 1'b1;
                ctl.issue_rd = 1'b1;
                state_next = S_ISSUE;
              end
            end
            CMD_RESP: begin
              if (sts.head_sent) begin
                ctl.out_status = ST_DONE;
                ctl.retire = 1'b1;
              end
            end
            default: ctl.out_status = ST_IDLE;
          endcase
        end
      end
      S_ISSUE: begin
        // Read data of the current word is registered; emit it.
        if (out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_issue = 1'b1;
          ctl.out_status = ST_DONE;
          ctl.out_last = sts.issue_end;
          if (sts.issue_end) state_next = S_IDLE;
          else state_next = S_OUT;
        end
      end
      S_OUT: begin
        ctl.issue_rd = 1'b1;
        state_next = S_ISSUE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mlwb_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merging line write buffer datapath
// Slot table, line store memory, match logic and result register.
// ----------------------------------------------------------------------------
module mlwb_dpath #(
  parameter int BUFFER_DEPTH = mlwb_pkg::DefBufferDepth,
  parameter int LINE_WORDS   = mlwb_pkg::DefLineWords
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [2:0]     in_cmd,
  input  wire logic [31:0]    in_addr,
  input  wire logic [3:0]     in_widx,
  input  wire logic [31:0]    in_data,
  input  wire logic [3:0]     in_strb,
  input  wire logic           in_lastw,
  input  wire mlwb_pkg::ctl_t ctl,
  output mlwb_pkg::sts_t      sts,
  input  wire logic           out_take,
  output logic                out_valid,
  output logic [2:0]          o_status,
  output logic [31:0]         o_data,
  output logic [31:0]         o_iaddr,
  output logic [3:0]          o_iidx,
  output logic                o_last,
  output logic                o_ready,
  output logic [3:0]          o_occ
);
  import mlwb_pkg::*;

  localparam int SW = $clog2(BUFFER_DEPTH);
  localparam int WW = $clog2(LINE_WORDS);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int OB = $clog2(LINE_WORDS * 4);

  logic [BUFFER_DEPTH-1:0] slot_valid, slot_sent;
  logic [31:0] slot_line_address [BUFFER_DEPTH];
  logic [31:0] line_store [BUFFER_DEPTH*LINE_WORDS];
  logic [SW-1:0] head_index, tail_index;
  logic [CW-1:0] entry_count;

  logic [2:0]  cmd;
  logic [31:0] addr, data;
  logic [3:0]  widx, strb;
  logic        lastw;

  logic [SW-1:0] hit_slot, m_slot;
  logic          hit_c, m_hit, m_sent;
  logic [31:0]   rd_word;
  logic [WW-1:0] iss_w;
  logic [WW-1:0] aw;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd <= in_cmd;
      addr <= in_addr;
      widx <= in_widx;
      data <= in_data;
      strb <= in_strb;
      lastw <= in_lastw;
    end
  end

  assign aw = addr[WW+1:2];

  // Youngest valid match: walk from head; later slots override.
  always_comb begin
    logic [SW-1:0] i;
    logic [SW:0]   j;
    hit_c = 1'b0;
    hit_slot = '0;
    for (int n = 0; n < BUFFER_DEPTH; n++) begin
      j = {1'b0, head_index} + (SW+1)'(n);
      if (32'(j) >= BUFFER_DEPTH) j = j - (SW+1)'(BUFFER_DEPTH);
      i = j[SW-1:0];
      if (CW'(n) < entry_count && slot_valid[i] &&
          slot_line_address[i][31:OB] == addr[31:OB]) begin
        hit_c = 1'b1;
        hit_slot = i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      m_hit <= hit_c;
      m_slot <= hit_slot;
      m_sent <= slot_sent[hit_slot];
    end
  end

  // Line store: one write port, one registered read port.
  logic [SW+WW-1:0] rd_addr;
  always_comb begin
    if (ctl.issue_rd) rd_addr = {head_index, ctl.mark_sent ? WW'(0) : iss_w};
    else rd_addr = {hit_slot, aw};
  end

  always_ff @(posedge clk) begin
    if (ctl.look || ctl.issue_rd) rd_word <= line_store[rd_addr];
  end

  logic [31:0] merged;
  always_comb begin
    for (int b = 0; b < 4; b++)
      merged[b*8 +: 8] = strb[b] ? data[b*8 +: 8] : rd_word[b*8 +: 8];
  end

  always_ff @(posedge clk) begin
    if (ctl.enq && 32'(widx) < LINE_WORDS)
      line_store[{tail_index, widx[WW-1:0]}] <= data;
    else if (ctl.merge_wr)
      line_store[{m_slot, aw}] <= merged;
  end

  always_ff @(posedge clk) begin
    if (ctl.enq && lastw)
      slot_line_address[tail_index] <= {addr[31:OB], OB'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_sent <= '0;
      head_index <= '0;
      tail_index <= '0;
      entry_count <= '0;
      iss_w <= '0;
    end else begin
      if (ctl.enq && lastw) begin
        slot_valid[tail_index] <= 1'b1;
        slot_sent[tail_index] <= 1'b0;
        tail_index <= (32'(tail_index) == BUFFER_DEPTH - 1) ? '0 : tail_index + 1'b1;
        entry_count <= entry_count + 1'b1;
      end
      if (ctl.mark_sent) slot_sent[head_index] <= 1'b1;
      if (ctl.retire) begin
        slot_valid[head_index] <= 1'b0;
        slot_sent[head_index] <= 1'b0;
        head_index <= (32'(head_index) == BUFFER_DEPTH - 1) ? '0 : head_index + 1'b1;
        entry_count <= entry_count - 1'b1;
      end
      if (ctl.issue_rd) iss_w <= ctl.mark_sent ? WW'(1) : iss_w + 1'b1;
    end
  end

  // Issue word index of the word now in rd_word.
  logic [WW-1:0] cur_w;
  assign cur_w = iss_w - 1'b1;

  assign sts.cmd = cmd_t'(cmd);
  assign sts.full = 32'(entry_count) >= BUFFER_DEPTH;
  assign sts.hit = m_hit;
  assign sts.hit_sent = m_sent;
  assign sts.head_ok = entry_count != '0 && slot_valid[head_index] &&
                       !slot_sent[head_index];
  assign sts.head_sent = slot_valid[head_index] && slot_sent[head_index];
  assign sts.issue_end = 32'(cur_w) == LINE_WORDS - 1;

  // Result register; occupancy is sampled after the step's update.
  logic [CW-1:0] cnt_after;
  always_comb begin
    cnt_after = entry_count;
    if (ctl.enq && lastw) cnt_after = entry_count + 1'b1;
    if (ctl.retire) cnt_after = entry_count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      o_status <= 3'(ctl.out_status);
      o_last <= ctl.out_last;
      o_iaddr <= ctl.out_issue ? slot_line_address[head_index] : '0;
      o_iidx <= ctl.out_issue ? 4'(cur_w) : '0;
      o_data <= (ctl.out_issue || (cmd == 3'(CMD_LOAD) && m_hit)) ? rd_word : '0;
      o_ready <= 32'(cnt_after) + 1 < BUFFER_DEPTH;
      o_occ <= 4'(cnt_after);
    end
  end

endmodule
`default_nettype wire

FILE: verif/mlwb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merging line write buffer checker
// Watches both stream channels, predicts every output word from accepted
// commands, and compares each output word field by field.
// ----------------------------------------------------------------------------
module mlwb_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [79:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [79:0] m_tdata,
  input  wire logic        m_tlast,
  output int               errors,
  output int               pending,
  output int               words_seen
);
  import mlwb_pkg::*;

  localparam int Depth = 8;
  localparam int Words = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [31:0] issue_address;
    logic [3:0]  issue_word_index;
    logic        last;
    logic        accept_ready;
    logic [3:0]  occupancy;
  } out_word_t;

  out_word_t   expected_words[$];
  logic        line_valid[Depth];
  logic        line_sent[Depth];
  logic [31:0] line_tag[Depth];
  logic [31:0] line_data[Depth*Words];
  logic [2:0]  head_slot;
  logic [2:0]  tail_slot;
  int          line_count;
  int          err_count;
  int          seen_count;

  assign errors     = err_count;
  assign pending    = expected_words.size();
  assign words_seen = seen_count;

  initial begin
    err_count  = 0;
    seen_count = 0;
    head_slot  = '0;
    tail_slot  = '0;
    line_count = 0;
    for (int i = 0; i < Depth; i++) begin
      line_valid[i] = 1'b0;
      line_sent[i]  = 1'b0;
      line_tag[i]   = '0;
    end
    for (int i = 0; i < Depth*Words; i++) line_data[i] = '0;
  end

  task automatic push_word(input logic [2:0] st, input logic [31:0] rd,
                           input logic [31:0] ia, input logic [3:0] iw,
                           input logic lst);
    out_word_t w;
    w.status           = st;
    w.read_data        = rd;
    w.issue_address    = ia;
    w.issue_word_index = iw;
    w.last             = lst;
    w.accept_ready     = (line_count + 1 < Depth);
    w.occupancy        = line_count[3:0];
    expected_words.push_back(w);
  endtask

  // Youngest committed line holding the line of the given address, or -1.
  function automatic int youngest_match(input logic [31:0] a);
    int hit;
    int s;
    hit = -1;
    s   = head_slot;
    for (int n = 0; n < line_count && n < Depth; n++) begin
      if (line_valid[s] && line_tag[s] == {a[31:6], 6'b0}) hit = s;
      s = (s + 1) % Depth;
    end
    return hit;
  endfunction

  task automatic predict_command(input logic [79:0] d, input logic lastw);
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [3:0]  widx;
    logic [31:0] data;
    logic [3:0]  strb;
    int          s;
    int          pos;
    cmd  = d[2:0];
    addr = d[34:3];
    widx = d[38:35];
    data = d[70:39];
    strb = d[74:71];
    case (cmd)
      CMD_ENQ: begin
        if (line_count >= Depth) begin
          push_word(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          line_data[tail_slot*Words + widx] = data;
          if (lastw) begin
            line_tag[tail_slot]   = {addr[31:6], 6'b0};
            line_valid[tail_slot] = 1'b1;
            line_sent[tail_slot]  = 1'b0;
            tail_slot             = tail_slot + 1'b1;
            line_count++;
          end
          push_word(ST_DONE, '0, '0, '0, 1'b1);
        end
      end
      CMD_MERGE, CMD_LOAD: begin
        s = youngest_match(addr);
        if (s < 0) begin
          push_word(ST_MISS, '0, '0, '0, 1'b1);
        end else begin
          pos = s*Words + addr[5:2];
          if (cmd == CMD_LOAD) begin
            push_word(ST_HIT, line_data[pos], '0, '0, 1'b1);
          end else if (line_sent[s]) begin
            push_word(ST_BUSY, '0, '0, '0, 1'b1);
          end else begin
            for (int b = 0; b < 4; b++)
              if (strb[b]) line_data[pos][b*8 +: 8] = data[b*8 +: 8];
            push_word(ST_HIT, '0, '0, '0, 1'b1);
          end
        end
      end
      CMD_ISSUE: begin
        if (line_count == 0 || !line_valid[head_slot] || line_sent[head_slot]) begin
          push_word(ST_IDLE, '0, '0, '0, 1'b1);
        end else begin
          line_sent[head_slot] = 1'b1;
          for (int w = 0; w < Words; w++)
            push_word(ST_DONE, line_data[head_slot*Words + w], line_tag[head_slot],
                      4'(w), w == Words - 1);
        end
      end
      CMD_RESP: begin
        if (line_valid[head_slot] && line_sent[head_slot]) begin
          line_valid[head_slot] = 1'b0;
          line_sent[head_slot]  = 1'b0;
          head_slot             = head_slot + 1'b1;
          if (line_count > 0) line_count--;
          push_word(ST_DONE, '0, '0, '0, 1'b1);
        end else begin
          push_word(ST_IDLE, '0, '0, '0, 1'b1);
        end
      end
      default: push_word(ST_IDLE, '0, '0, '0, 1'b1);
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch on output word %0d: %s got 0x%0h expected 0x%0h",
             seen_count, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_command(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", m_tdata[31:0], '0);
        end else begin
          w = expected_words.pop_front();
          if (m_tdata[2:0] != w.status) report("status", m_tdata[2:0], w.status);
          if (m_tdata[34:3] != w.read_data) report("read_data", m_tdata[34:3], w.read_data);
          if (m_tdata[66:35] != w.issue_address)
            report("issue_address", m_tdata[66:35], w.issue_address);
          if (m_tdata[70:67] != w.issue_word_index)
            report("issue_word_index", m_tdata[70:67], w.issue_word_index);
          if (m_tlast != w.last) report("last", m_tlast, w.last);
          if (m_tdata[71] != w.accept_ready)
            report("accept_ready", m_tdata[71], w.accept_ready);
          if (m_tdata[75:72] != w.occupancy) report("occupancy", m_tdata[75:72], w.occupancy);
          if (m_tdata[79:76] != 4'b0) report("zero fill", m_tdata[79:76], '0);
        end
        seen_count++;
      end
    end
  end

endmodule

FILE: verif/tb_merging_line_write_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merging line write buffer testbench
// Drives enqueue, merge, bypass, issue and response commands with random
// gaps and output stalls; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_merging_line_write_buffer;
  import mlwb_pkg::*;

  localparam logic [2:0] CmdFirstUnused = 3'd5;
  localparam logic [2:0] CmdLastUnused  = 3'd7;
  localparam int         Depth          = 8;
  localparam int         Words          = 16;
  localparam int         CycleLimit     = 400000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // command[2:0], address[34:3], word_index[38:35], data_word[70:39],
  // byte_strobe[74:71], zero fill to 80
  logic [79:0] s_tdata;
  logic        s_tlast;  // last_word
  logic        m_tvalid;
  logic        m_tready;
  // status[2:0], read_data[34:3], issue_address[66:35], issue_word_index[70:67],
  // accept_ready[71], occupancy[75:72], zero fill to 80
  logic [79:0] m_tdata;
  logic        m_tlast;

  int errors;
  int pending;
  int words_seen;
  int cycles;
  int sent_count;
  int lines_made;
  int fills_reached;
  int stubs;
  bit long_hold_req;

  // Shadow of what the stimulus has committed, so that it can aim its
  // lookups at held lines. Lines in held_addr are fully written; the
  // one-word lines of the final fill are kept apart from them.
  int          held_lines;
  bit          head_in_flight;
  logic [31:0] held_addr[$];

  merging_line_write_buffer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  mlwb_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .pending(pending), .words_seen(words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: mostly random ready, now and then a short burst of back
  // pressure, and one long hold-off on request so that the block fills up.
  initial begin
    m_tready      = 1'b0;
    long_hold_req = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else if ($urandom_range(0, 199) < 3) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  // Offer one command word and hold it until the block takes it. The valid
  // only drops when a gap is actually inserted.
  task automatic send(input logic [2:0] cmd, input logic [31:0] addr,
                      input logic [3:0] widx, input logic [31:0] data,
                      input logic [3:0] strb, input logic lastw);
    int gap;
    int r;
    r   = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, strb, data, widx, addr, cmd};
    s_tlast  <= lastw;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  // A whole line, every word written in order, committed on the last word.
  // When the buffer is full a few stray words go in and are dropped.
  task automatic enqueue_line(input logic [31:0] line_base);
    if (held_lines >= Depth) begin
      fills_reached++;
      repeat ($urandom_range(1, 3))
        send(CMD_ENQ, $urandom, 4'($urandom), $urandom, 4'($urandom), 1'($urandom));
    end else begin
      for (int w = 0; w < Words; w++)
        send(CMD_ENQ, {line_base[31:6], 6'($urandom)}, 4'(w), $urandom, 4'($urandom),
             w == Words - 1);
      held_addr.push_back({line_base[31:6], 6'b0});
      held_lines++;
      lines_made++;
    end
  endtask

  function automatic logic [31:0] pick_address();
    if (held_addr.size() > 0 && $urandom_range(0, 3) != 0)
      return {held_addr[$urandom_range(0, held_addr.size() - 1)][31:6], 6'($urandom)};
    return $urandom;
  endfunction

  // Word 0 of one of the one-word lines of the final fill.
  function automatic logic [31:0] stub_address();
    if (stubs == 0) return $urandom;
    return {20'hC0000, 6'($urandom_range(0, stubs - 1)), 4'h0, 2'($urandom)};
  endfunction

  task automatic issue_head();
    send(CMD_ISSUE, $urandom, 4'($urandom), $urandom, 4'($urandom), 1'($urandom));
    if (held_lines > 0 && !head_in_flight) head_in_flight = 1'b1;
  endtask

  task automatic respond();
    send(CMD_RESP, $urandom, 4'($urandom), $urandom, 4'($urandom), 1'($urandom));
    if (head_in_flight) begin
      void'(held_addr.pop_front());
      held_lines--;
      head_in_flight = 1'b0;
    end
  endtask

  task automatic lookup(input logic [2:0] cmd);
    send(cmd, pick_address(), 4'($urandom), $urandom, 4'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    sent_count     = 0;
    lines_made     = 0;
    fills_reached  = 0;
    stubs          = 0;
    held_lines     = 0;
    head_in_flight = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: operations on an empty buffer, then one line through
    // its whole life, with extreme addresses, data and strobes.
    issue_head();
    respond();
    send(CMD_LOAD, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 4'hF, 1'b1);
    send(CMD_MERGE, 32'h0, 4'h0, 32'h0, 4'h0, 1'b0);
    enqueue_line(32'hFFFF_FFC0);
    send(CMD_MERGE, 32'hFFFF_FFFC, 4'h0, 32'hA5A5_A5A5, 4'hF, 1'b0);
    send(CMD_MERGE, 32'hFFFF_FFC0, 4'hF, 32'hFFFF_FFFF, 4'h0, 1'b1);
    send(CMD_MERGE, 32'hFFFF_FFC4, 4'h0, 32'h1234_5678, 4'h5, 1'b0);
    send(CMD_LOAD, 32'hFFFF_FFFC, 4'h0, 32'h0, 4'h0, 1'b0);
    send(CMD_LOAD, 32'hFFFF_FFC4, 4'h0, 32'h0, 4'h0, 1'b0);
    send(CMD_LOAD, 32'h0000_0040, 4'h0, 32'h0, 4'h0, 1'b0);
    respond();
    issue_head();
    issue_head();
    send(CMD_MERGE, 32'hFFFF_FFC8, 4'h0, 32'hFFFF_FFFF, 4'hF, 1'b0);
    send(CMD_LOAD, 32'hFFFF_FFC8, 4'h0, 32'h0, 4'h0, 1'b0);
    respond();
    respond();
    for (logic [3:0] c = 4'(CmdFirstUnused); c <= 4'(CmdLastUnused); c++)
      send(c[2:0], $urandom, 4'($urandom), $urandom, 4'($urandom), 1'($urandom));

    // Sender pause: nothing more is offered until every word has come back.
    wait_drained();

    // Random part: lines with random content and a mix of lookups, issues
    // and responses, plus stray unknown commands.
    while (sent_count < 92) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) enqueue_line(pick_address());
      else if (pick < 50) lookup(CMD_MERGE);
      else if (pick < 68) lookup(CMD_LOAD);
      else if (pick < 82) issue_head();
      else if (pick < 95) respond();
      else send(3'($urandom_range(CmdFirstUnused, CmdLastUnused)), $urandom,
                4'($urandom), $urandom, 4'($urandom), 1'($urandom));
    end

    // Fill to the brim with one-word lines while the receiver holds off, so
    // the block stalls its input, then probe a full buffer. Only word 0 of
    // these lines is written, so lookups aim there and none is issued.
    long_hold_req = 1'b1;
    while (held_lines < Depth) begin
      send(CMD_ENQ, {20'hC0000, 6'(stubs), 6'($urandom)}, 4'h0, $urandom,
           4'($urandom), 1'b1);
      stubs++;
      held_lines++;
      lines_made++;
    end
    enqueue_line($urandom);
    repeat (4)
      send(CMD_MERGE, stub_address(), 4'($urandom), $urandom, 4'($urandom), 1'($urandom));
    repeat (3)
      send(CMD_LOAD, stub_address(), 4'($urandom), $urandom, 4'($urandom), 1'($urandom));

    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d command words, %0d committed lines, %0d full-buffer drops",
             sent_count, lines_made, fills_reached);
    $display("%0d output words checked, %0d mismatches", words_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mlwb_pkg.sv
rtl/mlwb_ctrl.sv
rtl/mlwb_dpath.sv
rtl/merging_line_write_buffer.sv
verif/mlwb_checker.sv
verif/tb_merging_line_write_buffer.sv
